[hw/rtl/tfn_pkg.sv]
// Shared constants and types for the triangle face normal pipeline.
// No dependencies; imported by tfn_root_step, triangle_face_normal and the testbench.
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // Sideband that rides along with each triangle through the pipeline.
  typedef struct packed {
    logic [2:0] neg;   // sign of each cross product component
    logic       deg;   // cross product is zero
  } tfn_tag_t;

endpackage

[hw/rtl/tfn_root_step.sv]
// One pipeline stage of the rounded unit-normal search: decides bit K of all three
// quotients. Depends on tfn_pkg for the sideband type.
`timescale 1ns / 1ps
module tfn_root_step
  import tfn_pkg::*;
#(
  parameter int WB = 103,
  parameter int SB = 70,
  parameter int QB = 15,
  parameter int K  = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0][WB-1:0]     in_p,
  input  logic [2:0][WB-1:0]     in_r,
  input  logic [2:0][WB-1:0]     in_t,
  input  logic [2:0][QB-1:0]     in_q,
  input  logic [SB-1:0]          in_s,
  input  tfn_tag_t               in_tag,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0][WB-1:0]     out_p,
  output logic [2:0][WB-1:0]     out_r,
  output logic [2:0][WB-1:0]     out_t,
  output logic [2:0][QB-1:0]     out_q,
  output logic [SB-1:0]          out_s,
  output tfn_tag_t               out_tag
);

  logic                   adv;
  logic signed [WB-1:0]   s_ext;
  logic [2:0][WB-1:0]     p_next;
  logic [2:0][WB-1:0]     r_next;
  logic [2:0][QB-1:0]     q_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign s_ext    = $signed(WB'(in_s));

  // d tracks 2q-1; P = d*d*S, R = d*S. Trying bit K adds 2^(K+1) to d.
  always_comb begin
    logic signed [WB-1:0] trial;
    logic [QB-1:0]        qt;
    for (int i = 0; i < 3; i++) begin
      trial = $signed(in_p[i]) + ($signed(in_r[i]) <<< (K + 2)) + (s_ext <<< (2 * K + 2));
      qt    = in_q[i];
      qt[K] = 1'b1;
      if (trial <= $signed(in_t[i])) begin
        p_next[i] = trial;
        r_next[i] = $signed(in_r[i]) + (s_ext <<< (K + 1));
        q_next[i] = qt;
      end else begin
        p_next[i] = in_p[i];
        r_next[i] = in_r[i];
        q_next[i] = in_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_p   <= p_next;
      out_r   <= r_next;
      out_t   <= in_t;
      out_q   <= q_next;
      out_s   <= in_s;
      out_tag <= in_tag;
    end
  end

endmodule

[hw/rtl/triangle_face_normal.sv]
// Top level of the triangle unit face normal pipeline.
// Depends on tfn_pkg and tfn_root_step.
`timescale 1ns / 1ps
// Takes one triangle per word (three vertices, signed fixed point) and returns
// its unit face normal in signed fixed point with NORMAL_FRAC_BITS fraction
// bits, rounded to nearest with ties away from zero. A collinear or
// coincident triangle gives a zero normal with the degenerate flag set.
// The unit accepts one triangle every cycle while the output is not stalled.
// It has 5 register stages of setup and squaring, one stage per quotient bit
// for the bit-per-stage normalizing search, and one output stage.
// Each stage holds its word while the next one is full and stalled, so a stalled
// output backs up without loss and bubbles are squeezed out.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz from the lowest bit up
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]          s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // normal_x, normal_y, normal_z from the lowest bit up
  output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
  // degenerate
  output logic                                      m_tuser
);

  localparam int CB   = COORD_BITS;
  localparam int F    = NORMAL_FRAC_BITS;
  localparam int NB   = F + 2;
  localparam int EB   = CB + 1;          // edge
  localparam int PB   = 2 * EB;          // edge product
  localparam int XB   = PB + 1;          // cross component
  localparam int MAGB = 2 * CB + 2;      // cross magnitude
  localparam int H    = CB + 1;          // low half of magnitude
  localparam int HB   = MAGB - H;        // high half
  localparam int SQB  = 2 * MAGB;
  localparam int SB   = SQB + 2;
  localparam int WB   = 2 * F + SB + 5;
  localparam int QB   = F + 1;
  localparam int OB   = ((3 * NB + 7) / 8) * 8;

  // ---- stage 1: edges ----
  logic                       v1, a1;
  logic signed [2:0][EB-1:0]  e1, e2;
  // ---- stage 2: edge products ----
  logic                       v2, a2;
  logic signed [5:0][PB-1:0]  pr;
  // ---- stage 3: cross product magnitude and sign ----
  logic                       v3, a3;
  logic [2:0][MAGB-1:0]       mg;
  tfn_tag_t                   tag3;
  // ---- stage 4: partial squares ----
  logic                       v4, a4;
  logic [2:0][2*HB-1:0]       hh;
  logic [2:0][HB+H-1:0]       hl;
  logic [2:0][2*H-1:0]        ll;
  tfn_tag_t                   tag4;
  // ---- stage 5: squared length and search seed ----
  logic                       v5, a5;
  logic [2:0][WB-1:0]         s5_p, s5_r, s5_t;
  logic [2:0][QB-1:0]         s5_q;
  logic [SB-1:0]              s5_s;
  tfn_tag_t                   tag5;

  logic [F+1:0]               ch_v, ch_rdy;
  logic [F+1:0][2:0][WB-1:0]  ch_p, ch_r, ch_t;
  logic [F+1:0][2:0][QB-1:0]  ch_q;
  logic [F+1:0][SB-1:0]       ch_s;
  tfn_tag_t [F+1:0]           ch_tag;

  // ---- output ----
  logic                       ao;
  logic [2:0][NB-1:0]         nrm;
  logic                       deg_o;

  assign ao       = !m_tvalid || m_tready;
  assign a5       = !v5 || ch_rdy[0];
  assign a4       = !v4 || a5;
  assign a3       = !v3 || a4;
  assign a2       = !v2 || a3;
  assign a1       = !v1 || a2;
  assign s_tready = a1;

  assign ch_v[0]       = v5;
  assign ch_rdy[F+1]   = ao;

  assign ch_p[0]   = s5_p;
  assign ch_r[0]   = s5_r;
  assign ch_t[0]   = s5_t;
  assign ch_q[0]   = s5_q;
  assign ch_s[0]   = s5_s;
  assign ch_tag[0] = tag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (a1) v1 <= s_tvalid;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
      if (a4) v4 <= v3;
      if (a5) v5 <= v4;
      if (ao) m_tvalid <= ch_v[F+1];
    end
  end

  // Stage 1: form b-a and c-a exactly.
  always_ff @(posedge clk) begin
    if (a1 && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EB'($signed(s_tdata[CB*(3+i) +: CB])) - EB'($signed(s_tdata[CB*i +: CB]));
        e2[i] <= EB'($signed(s_tdata[CB*(6+i) +: CB])) - EB'($signed(s_tdata[CB*i +: CB]));
      end
    end
  end

  // Stage 2: the edge products of the cross product, a pair for each component.
  always_ff @(posedge clk) begin
    if (a2 && v1) begin
      pr[0] <= PB'($signed(e1[1]) * $signed(e2[2]));
      pr[1] <= PB'($signed(e1[2]) * $signed(e2[1]));
      pr[2] <= PB'($signed(e1[2]) * $signed(e2[0]));
      pr[3] <= PB'($signed(e1[0]) * $signed(e2[2]));
      pr[4] <= PB'($signed(e1[0]) * $signed(e2[1]));
      pr[5] <= PB'($signed(e1[1]) * $signed(e2[0]));
    end
  end

  // Stage 3: subtract, split into sign and magnitude, flag a zero vector.
  always_ff @(posedge clk) begin
    logic signed [XB-1:0] n;
    logic                 zero;
    if (a3 && v2) begin
      zero = 1'b1;
      for (int i = 0; i < 3; i++) begin
        n = XB'($signed(pr[2*i])) - XB'($signed(pr[2*i+1]));
        tag3.neg[i] <= n[XB-1];
        mg[i]       <= n[XB-1] ? MAGB'(-n) : MAGB'(n);
        if (n != '0) zero = 1'b0;
      end
      tag3.deg <= zero;
    end
  end

  // Stage 4: square each magnitude as three half-width products.
  always_ff @(posedge clk) begin
    if (a4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mg[i][MAGB-1:H] * mg[i][MAGB-1:H];
        hl[i] <= mg[i][MAGB-1:H] * mg[i][H-1:0];
        ll[i] <= mg[i][H-1:0] * mg[i][H-1:0];
      end
      tag4 <= tag3;
    end
  end

  // Stage 5: assemble squares, sum S, target T = 4 m^2 2^(2F); seed d = -1.
  always_ff @(posedge clk) begin
    logic [SQB-1:0] sq;
    logic [SB-1:0]  sum;
    if (a5 && v4) begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        sq = (SQB'(hh[i]) << (2 * H)) + (SQB'(hl[i]) << (H + 1)) + SQB'(ll[i]);
        sum = sum + SB'(sq);
        s5_t[i] <= WB'(sq) << (2 * F + 2);
        s5_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        s5_p[i] <= WB'(sum);
        s5_r[i] <= -WB'(sum);
      end
      s5_s <= sum;
      tag5 <= tag4;
    end
  end

  // One stage per quotient bit, most significant first.
  for (genvar g = 0; g <= F; g++) begin : g_step
    tfn_root_step #(
      .WB (WB),
      .SB (SB),
      .QB (QB),
      .K  (F - g)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (ch_v[g]),
      .in_ready  (ch_rdy[g]),
      .in_p      (ch_p[g]),
      .in_r      (ch_r[g]),
      .in_t      (ch_t[g]),
      .in_q      (ch_q[g]),
      .in_s      (ch_s[g]),
      .in_tag    (ch_tag[g]),
      .out_valid (ch_v[g+1]),
      .out_ready (ch_rdy[g+1]),
      .out_p     (ch_p[g+1]),
      .out_r     (ch_r[g+1]),
      .out_t     (ch_t[g+1]),
      .out_q     (ch_q[g+1]),
      .out_s     (ch_s[g+1]),
      .out_tag   (ch_tag[g+1])
    );
  end

  // Output: restore signs, force zero on a degenerate triangle.
  always_ff @(posedge clk) begin
    if (ao && ch_v[F+1]) begin
      for (int i = 0; i < 3; i++) begin
        if (ch_tag[F+1].deg) begin
          nrm[i] <= '0;
        end else if (ch_tag[F+1].neg[i]) begin
          nrm[i] <= -NB'(ch_q[F+1][i]);
        end else begin
          nrm[i] <= NB'(ch_q[F+1][i]);
        end
      end
      deg_o <= ch_tag[F+1].deg;
    end
  end

  assign m_tdata = OB'({nrm[2], nrm[1], nrm[0]});
  assign m_tuser = deg_o;

endmodule

[test/testbench.sv]
// Self-checking bench for triangle_face_normal: directed triangles, then random ones.
// Depends on tfn_pkg and the triangle_face_normal RTL only.
`timescale 1ns / 1ps
module testbench;
  import tfn_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int NF = NORMAL_FRAC_BITS_DEF;
  localparam int OB = NF + 2;
  localparam int DW = ((9 * CB + 7) / 8) * 8;
  localparam int RW = ((3 * OB + 7) / 8) * 8;
  localparam int N_RANDOM = 1250;
  localparam int LATENCY = NF + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [OB-1:0] nx, ny, nz;
    logic                 deg;
  } normal_t;

  // One directed triangle: a, b, c as x, y, z each; the typed result is
  // used only where it is obvious by inspection.
  typedef struct {
    int      v[9];
    bit      typed;
    normal_t res;
  } tri_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [RW-1:0] m_tdata;
  logic          m_tuser;

  normal_t pending_normals[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      no_idle = 1'b0;
  int      out_stall = 0;

  triangle_face_normal uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch @%0d: %s", cycles, what);
    errors++;
  endtask

  function automatic longint coord_of(input logic [DW-1:0] w, input int idx);
    logic signed [CB-1:0] c;
    c = w[idx*CB +: CB];
    return longint'(c);
  endfunction

  // Nearest integer to m * 2^NF / sqrt(sum), ties away from zero: the
  // largest q with (2q-1)^2 * sum <= m^2 * 2^(2NF+2).
  function automatic int unit_component(input logic [63:0] m, input logic [127:0] sum);
    logic [127:0] target, d, lhs;
    int lo, hi, mid;
    target = ({64'd0, m} * {64'd0, m}) << (2 * NF + 2);
    lo = 0;
    hi = 1 << NF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 128'(2 * mid - 1);
      lhs = d * d * sum;
      if (lhs <= target) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic normal_t face_normal(input logic [DW-1:0] w);
    longint e1[3], e2[3], n[3];
    logic [63:0] m[3];
    logic [127:0] sum;
    normal_t r;
    int q[3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = coord_of(w, 3 + i) - coord_of(w, i);
      e2[i] = coord_of(w, 6 + i) - coord_of(w, i);
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.nx = '0; r.ny = '0; r.nz = '0;
    r.deg = (n[0] == 0 && n[1] == 0 && n[2] == 0);
    if (r.deg) return r;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      sum += {64'd0, m[i]} * {64'd0, m[i]};
    end
    for (int i = 0; i < 3; i++) begin
      q[i] = unit_component(m[i], sum);
      if (n[i] < 0) q[i] = -q[i];
    end
    r.nx = OB'(q[0]); r.ny = OB'(q[1]); r.nz = OB'(q[2]);
    return r;
  endfunction

  function automatic logic [DW-1:0] pack_tri(input int v[9]);
    logic [DW-1:0] w;
    w = '0;
    for (int i = 0; i < 9; i++) w[i*CB +: CB] = CB'(v[i]);
    return w;
  endfunction

  // Send one triangle and queue its expected normal once accepted.
  task automatic send_tri(input logic [DW-1:0] w, input normal_t res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    pending_normals.push_back(res);
  endtask

  // Output side: check each accepted word, then draw the next stall.
  always @(posedge clk) begin
    normal_t exp_n;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_normals.size() == 0) begin
          report("normal word with nothing expected");
        end else begin
          exp_n = pending_normals.pop_front();
          if (m_tdata[0 +: OB] !== exp_n.nx)
            report($sformatf("normal_x %0d, want %0d",
                             $signed(m_tdata[0 +: OB]), exp_n.nx));
          if (m_tdata[OB +: OB] !== exp_n.ny)
            report($sformatf("normal_y %0d, want %0d",
                             $signed(m_tdata[OB +: OB]), exp_n.ny));
          if (m_tdata[2*OB +: OB] !== exp_n.nz)
            report($sformatf("normal_z %0d, want %0d",
                             $signed(m_tdata[2*OB +: OB]), exp_n.nz));
          if (m_tuser !== exp_n.deg)
            report($sformatf("degenerate %b, want %b", m_tuser, exp_n.deg));
        end
        out_stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        m_tready <= 1'b0;
        out_stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int rnd_coord(input int span);
    if (span >= 32768) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    tri_row_t rows[$];
    tri_row_t r;
    normal_t zero_n, up_n, down_n, res;
    int v[9];
    int k, mode, span;

    zero_n = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
    up_n   = '{nx: '0, ny: '0, nz: OB'(1 << NF), deg: 1'b0};
    down_n = '{nx: '0, ny: '0, nz: -OB'(1 << NF), deg: 1'b0};

    // All vertices coincident at the origin and at both extremes.
    rows.push_back('{'{0,0,0, 0,0,0, 0,0,0}, 1, zero_n});
    rows.push_back('{'{-32768,-32768,-32768, -32768,-32768,-32768,
                       -32768,-32768,-32768}, 1, zero_n});
    rows.push_back('{'{32767,32767,32767, 32767,32767,32767,
                       32767,32767,32767}, 1, zero_n});
    // Right triangle with legs of 256 in the xy plane, both windings.
    rows.push_back('{'{0,0,0, 256,0,0, 0,256,0}, 1, up_n});
    rows.push_back('{'{0,0,0, 0,256,0, 256,0,0}, 1, down_n});
    // Longest edges the coordinates allow.
    rows.push_back('{'{-32768,-32768,-32768, 32767,-32768,-32768,
                       -32768,32767,-32768}, 1, up_n});
    rows.push_back('{'{-32768,-32768,-32768, -32768,32767,-32768,
                       32767,-32768,-32768}, 1, down_n});
    // Collinear along the main diagonal and along an axis.
    rows.push_back('{'{-32768,-32768,-32768, 0,0,0, 32767,32767,32767}, 1, zero_n});
    rows.push_back('{'{-32768,5,5, 0,5,5, 32767,5,5}, 1, zero_n});
    // Two vertices coincide.
    rows.push_back('{'{100,-200,300, 100,-200,300, -7,9,11}, 1, zero_n});
    // Tiny triangles and others left to the predictor.
    rows.push_back('{'{0,0,0, 1,0,0, 0,1,1}, 0, zero_n});
    rows.push_back('{'{0,0,0, 1,1,0, 0,1,1}, 0, zero_n});
    rows.push_back('{'{0,0,0, 1,2,3, 3,2,1}, 0, zero_n});
    rows.push_back('{'{32767,-32768,32767, -32768,32767,-32768, 32767,32767,-32768}, 0, zero_n});
    rows.push_back('{'{-32768,32767,0, 32767,0,-32768, 0,-32768,32767}, 0, zero_n});
    rows.push_back('{'{1,-1,1, -1,1,-1, 1,1,-1}, 0, zero_n});
    rows.push_back('{'{0,0,0, 3,0,0, 0,4,0}, 0, zero_n});
    rows.push_back('{'{0,0,0, 1,0,0, 0,1,2}, 0, zero_n});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      r = rows[i];
      res = r.typed ? r.res : face_normal(pack_tri(r.v));
      send_tri(pack_tri(r.v), res);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = ((n / 150) % 3 == 1);
      mode = $urandom_range(0, 9);
      span = (mode < 5) ? 32768 : (mode < 7 ? 300 : 3);
      for (int i = 0; i < 9; i++) v[i] = rnd_coord(span);
      if (mode == 7) begin
        // Collinear: c = a + k * (b - a), kept small enough to stay in range.
        k = int'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) begin
          v[i] = rnd_coord(1000);
          v[3+i] = v[i] + rnd_coord(1000);
          v[6+i] = v[i] + k * (v[3+i] - v[i]);
        end
      end else if (mode == 8) begin
        // Two vertices coincide.
        for (int i = 0; i < 3; i++) v[6+i] = v[$urandom_range(0, 1) * 3 + i];
      end
      send_tri(pack_tri(v), face_normal(pack_tri(v)));
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (pending_normals.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[triangle_face_normal.f]
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_root_step.sv
hw/rtl/triangle_face_normal.sv
test/testbench.sv
